@@ rtl/tccw_pkg.sv @@
package tccw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    // Field widths, fixed by the port list
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int ADDR_W     = 11;
    localparam int CHAR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int COLOUR_W   = 4;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [ADDR_W-1:0] CELL_TOTAL = ADDR_W'(CELL_COUNT);

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'd32;

    localparam logic [CELL_W-1:0] RESET_BLANK = {8'h00, CHAR_BLANK};

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOREGROUND = 1'b0,
        REG_BACKGROUND = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCR_RD,
        S_SCR_WR,
        S_FILL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic init_write;
        logic fill_write;
        logic scroll_read;
        logic scroll_write;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic need_scroll;
        logic sweep_last;
        logic copy_last;
        logic out_free;
    } t_status;

endpackage

@@ rtl/tccw_ctrl.sv @@
module tccw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tccw_pkg::t_status i_status,
    output tccw_pkg::t_cmd    o_cmd
);

    tccw_pkg::t_state r_state;
    tccw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tccw_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tccw_pkg::S_INIT: begin
                if (i_status.sweep_last) n_state = tccw_pkg::S_IDLE;
            end
            tccw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.is_clear) n_state = tccw_pkg::S_FILL;
                    else if (i_status.need_scroll) n_state = tccw_pkg::S_SCR_RD;
                    else n_state = tccw_pkg::S_DONE;
                end
            end
            tccw_pkg::S_SCR_RD: n_state = tccw_pkg::S_SCR_WR;
            tccw_pkg::S_SCR_WR: begin
                n_state = i_status.copy_last ? tccw_pkg::S_FILL : tccw_pkg::S_SCR_RD;
            end
            tccw_pkg::S_FILL: begin
                if (i_status.sweep_last) n_state = tccw_pkg::S_DONE;
            end
            tccw_pkg::S_DONE: begin
                if (i_status.out_free) n_state = tccw_pkg::S_IDLE;
            end
            default: n_state = tccw_pkg::S_INIT;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            tccw_pkg::S_INIT: o_cmd.init_write = 1'b1;
            tccw_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.accept   = i_in_valid;
            end
            tccw_pkg::S_SCR_RD: o_cmd.scroll_read  = 1'b1;
            tccw_pkg::S_SCR_WR: o_cmd.scroll_write = 1'b1;
            tccw_pkg::S_FILL:   o_cmd.fill_write   = 1'b1;
            tccw_pkg::S_DONE:   o_cmd.load_out     = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ rtl/tccw_dp.sv @@
module tccw_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tccw_pkg::t_cmd                  i_cmd,
    output tccw_pkg::t_status               o_status,
    input  logic                            i_cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [tccw_pkg::KIND_W-1:0]     i_kind,
    input  logic [tccw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tccw_pkg::ADDR_W-1:0]     i_cell_index,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [tccw_pkg::CELL_W-1:0]     o_cell_data,
    output logic [tccw_pkg::ROW_W-1:0]      o_cursor_row,
    output logic [tccw_pkg::COL_W-1:0]      o_cursor_column
);

    logic [tccw_pkg::CELL_W-1:0]   r_mem [tccw_pkg::CELL_COUNT];
    logic [tccw_pkg::CELL_W-1:0]   r_rd_data;
    logic [tccw_pkg::COLOUR_W-1:0] r_fg;
    logic [tccw_pkg::COLOUR_W-1:0] r_bg;
    logic [tccw_pkg::ROW_W-1:0]    r_row;
    logic [tccw_pkg::ROW_W-1:0]    n_row;
    logic [tccw_pkg::COL_W-1:0]    r_col;
    logic [tccw_pkg::COL_W-1:0]    n_col;
    logic [tccw_pkg::ADDR_W-1:0]   r_sweep;
    logic                          r_is_read;
    logic                          r_out_valid;
    logic [tccw_pkg::CELL_W-1:0]   r_out_data;
    logic [tccw_pkg::ROW_W-1:0]    r_out_row;
    logic [tccw_pkg::COL_W-1:0]    r_out_col;

    logic                          wr_put;
    logic                          last_row;
    logic                          rd_item;
    logic [tccw_pkg::ADDR_W-1:0]   cursor_addr;
    logic [tccw_pkg::CELL_W-1:0]   blank;
    logic                          mem_we;
    logic [tccw_pkg::ADDR_W-1:0]   mem_waddr;
    logic [tccw_pkg::CELL_W-1:0]   mem_wdata;
    logic                          mem_re;
    logic [tccw_pkg::ADDR_W-1:0]   mem_raddr;

    assign last_row    = (r_row == tccw_pkg::ROW_LAST);
    assign cursor_addr = tccw_pkg::ADDR_W'(tccw_pkg::ADDR_W'(r_row)
                         * tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS))
                         + tccw_pkg::ADDR_W'(r_col);
    assign blank       = {r_bg, r_fg, tccw_pkg::CHAR_BLANK};
    assign rd_item     = i_cmd.accept && (i_kind == tccw_pkg::KIND_READ)
                         && (i_cell_index < tccw_pkg::CELL_TOTAL);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= '0;
            r_bg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tccw_pkg::REG_FOREGROUND: r_fg <= i_cfg_data;
                tccw_pkg::REG_BACKGROUND: r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Cursor update on an accepted item
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        wr_put = 1'b0;
        if (i_cmd.accept) begin
            case (i_kind)
                tccw_pkg::KIND_PUT: begin
                    if (i_char_code == tccw_pkg::CHAR_NEWLINE) begin
                        n_col = '0;
                        if (!last_row) n_row = r_row + 1'b1;
                    end else if (i_char_code == tccw_pkg::CHAR_RETURN) begin
                        n_col = '0;
                    end else begin
                        wr_put = 1'b1;
                        if (r_col == tccw_pkg::COL_LAST) begin
                            n_col = '0;
                            if (!last_row) n_row = r_row + 1'b1;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                end
                tccw_pkg::KIND_CLEAR: begin
                    n_row = '0;
                    n_col = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Sweep address: clearing pass, row copy and blank fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.accept) begin
            r_sweep <= '0;
        end else if (i_cmd.init_write || i_cmd.fill_write || i_cmd.scroll_write) begin
            r_sweep <= r_sweep + 1'b1;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sweep;
        mem_wdata = blank;
        if (i_cmd.init_write) begin
            mem_we    = 1'b1;
            mem_wdata = tccw_pkg::RESET_BLANK;
        end else if (i_cmd.fill_write) begin
            mem_we    = 1'b1;
        end else if (i_cmd.scroll_write) begin
            mem_we    = 1'b1;
            mem_wdata = r_rd_data;
        end else if (wr_put) begin
            mem_we    = 1'b1;
            mem_waddr = cursor_addr;
            mem_wdata = {r_bg, r_fg, i_char_code};
        end
    end

    assign mem_re    = i_cmd.scroll_read || rd_item;
    assign mem_raddr = i_cmd.scroll_read
                       ? r_sweep + tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS)
                       : i_cell_index;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_is_read <= rd_item;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= r_is_read ? r_rd_data : '0;
            r_out_row  <= r_row;
            r_out_col  <= r_col;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cell_data     = r_out_data;
    assign o_cursor_row    = r_out_row;
    assign o_cursor_column = r_out_col;

    assign o_status.is_clear    = (i_kind == tccw_pkg::KIND_CLEAR);
    assign o_status.need_scroll = (i_kind == tccw_pkg::KIND_PUT) && last_row
                                  && ((i_char_code == tccw_pkg::CHAR_NEWLINE)
                                  || ((i_char_code != tccw_pkg::CHAR_RETURN)
                                  && (r_col == tccw_pkg::COL_LAST)));
    assign o_status.sweep_last  = (r_sweep == tccw_pkg::CELL_LAST);
    assign o_status.copy_last   = (r_sweep == tccw_pkg::COPY_LAST);
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

endmodule

@@ rtl/text_console_cell_writer_top.sv @@
// Text-mode console writer over an 80 x 25 screen of 16-bit cells (attribute
// byte high, character low) with a cursor. Each accepted item gives exactly
// one result that reports the cursor after the item, plus the cell for a read of an index on the screen.
// After reset the block runs a clearing pass over all 2000 cells, one cell per
// cycle, before it takes the first item; configuration writes are taken
// throughout. Item cost is set by the sequencer and its sweep counter: a put,
// newline, return, read or unused kind goes from acceptance straight to the
// result state, which loads the output register once it is free, and the
// next item is taken after that; a clear sweeps all 2000 cells with blanks
// before its result; a put or newline that runs past the bottom row scrolls,
// copying 1920 cells, each read in one state and written in the next, and
// blanking the last 80 before its result. One item is worked on at a time;
// the next item is accepted while the previous result still waits in the
// output register.
module text_console_cell_writer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [tccw_pkg::KIND_W-1:0]     i_kind,
    input  logic [tccw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tccw_pkg::ADDR_W-1:0]     i_cell_index,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [tccw_pkg::CELL_W-1:0]     o_cell_data,
    output logic [tccw_pkg::ROW_W-1:0]      o_cursor_row,
    output logic [tccw_pkg::COL_W-1:0]      o_cursor_column
);

    tccw_pkg::t_cmd    cmd;
    tccw_pkg::t_status status;

    // Sequencer: clearing pass, item acceptance, scroll and fill sweeps
    tccw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Screen store, cursor, colours and the output register
    tccw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_char_code     (i_char_code),
        .i_cell_index    (i_cell_index),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_cell_data     (o_cell_data),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_column (o_cursor_column)
    );

    // Hold off new items unless the sequencer is idle
    assign o_in_stall = !cmd.in_ready;

endmodule

@@ rtl/tccw_checker.sv @@
module tccw_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [tccw_pkg::CELL_W-1:0]     o_cell_data,
    input logic [tccw_pkg::ROW_W-1:0]      o_cursor_row,
    input logic [tccw_pkg::COL_W-1:0]      o_cursor_column
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cell_data)
            && $stable(o_cursor_row) && $stable(o_cursor_column))
        else $error("stalled result changed");

    // Cursor never leaves the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cursor_row < tccw_pkg::ROW_LAST + 1'b1)
            && (o_cursor_column < tccw_pkg::COL_LAST + 1'b1))
        else $error("cursor outside the screen");

    // Clearing pass blocks items right after reset
    a_init_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("item taken during clearing pass");

    // One item in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken back to back");

endmodule

bind text_console_cell_writer_top tccw_checker u_tccw_checker (.*);
